// ===== sv/s5gp_pkg.sv =====
// Package: shared types, codes and constants for the SOCKS5 greeting/request parser.
package s5gp_pkg;

   // Parse phases
   typedef enum logic [3:0] {
      PH_GREET_VER = 4'd0,
      PH_NMETHODS  = 4'd1,
      PH_METHODS   = 4'd2,
      PH_REQ_VER   = 4'd3,
      PH_CMD       = 4'd4,
      PH_RSV       = 4'd5,
      PH_ATYP      = 4'd6,
      PH_HOSTLEN   = 4'd7,
      PH_ADDR      = 4'd8,
      PH_PORT_HI   = 4'd9,
      PH_PORT_LO   = 4'd10
   } phase_type;

   // Verdict codes
   typedef enum logic [2:0] {
      V_UNFINISHED = 3'd0,
      V_GRANTED    = 3'd1,
      V_AUTH_VER   = 3'd2,
      V_NO_METHOD  = 3'd3,
      V_PROTO      = 3'd4,
      V_IGNORED    = 3'd5
   } verdict_type;

   // Address kinds
   typedef enum logic [1:0] {
      KIND_IPV4 = 2'd0,
      KIND_HOST = 2'd1,
      KIND_IPV6 = 2'd2
   } kind_type;

   // Protocol byte values
   localparam logic [7:0] SOCKS_VERSION = 8'h05;
   localparam logic [7:0] METHOD_NOAUTH = 8'h00;
   localparam logic [7:0] CMD_CONNECT   = 8'h01;
   localparam logic [7:0] RSV_VALUE     = 8'h00;
   localparam logic [7:0] ATYP_IPV4     = 8'h01;
   localparam logic [7:0] ATYP_IPV6     = 8'h04;
   localparam logic [7:0] IPV4_LEN      = 8'd4;
   localparam logic [7:0] IPV6_LEN      = 8'd16;

   // Input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_connection;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [2:0]  verdict;
      logic [1:0]  addr_kind;
      logic        addr_byte_valid;
      logic [7:0]  addr_index;
      logic [7:0]  addr_byte;
      logic [15:0] dest_port;
   } rsp_word_type;

   // Parser state carried from byte to byte
   typedef struct packed {
      phase_type  parse_phase;
      logic [7:0] methods_remaining;
      logic       no_auth_offered;
      kind_type   address_kind_held;
      logic [7:0] address_bytes_left;
      logic [7:0] address_position;
      logic [7:0] port_high_byte;
      logic       verdict_given;
   } parser_state_type;

   localparam parser_state_type STATE_RESET = '{
      parse_phase:        PH_GREET_VER,
      methods_remaining:  8'd0,
      no_auth_offered:    1'b0,
      address_kind_held:  KIND_IPV4,
      address_bytes_left: 8'd0,
      address_position:   8'd0,
      port_high_byte:     8'd0,
      verdict_given:      1'b0
   };

   // Handshake between the input stage and the parser core
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } stage_word_type;

endpackage

// ===== sv/s5gp_if.sv =====
// Interfaces: request and response channels of the parser (valid/ready with payload).
interface s5gp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_connection;

   modport source (output valid, output data_byte, output new_connection, input ready);
   modport sink   (input valid, input data_byte, input new_connection, output ready);
endinterface

interface s5gp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [1:0]  addr_kind;
   logic        addr_byte_valid;
   logic [7:0]  addr_index;
   logic [7:0]  addr_byte;
   logic [15:0] dest_port;

   modport source (output valid, output verdict, output addr_kind, output addr_byte_valid,
                   output addr_index, output addr_byte, output dest_port, input ready);
   modport sink   (input valid, input verdict, input addr_kind, input addr_byte_valid,
                   input addr_index, input addr_byte, input dest_port, output ready);
endinterface

// ===== sv/s5gp_in_stage.sv =====
// Input register stage: captures one request word per cycle while it is empty or the downstream stage is ready.
module s5gp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  s5gp_pkg::req_word_type in_word,
   output logic                  in_ready,
   input  logic                  down_ready,
   output s5gp_pkg::stage_word_type out_stage
);
   import s5gp_pkg::*;

   logic         valid_ff, valid_in;
   req_word_type word_ff;

   // stage may load when empty or when its word moves on this cycle
   assign in_ready = !valid_ff || down_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

   assign out_stage.valid = valid_ff;
   assign out_stage.word  = word_ff;
endmodule

// ===== sv/s5gp_core.sv =====
// Parser core: per-byte state update and registered result word.
module s5gp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  s5gp_pkg::stage_word_type in_stage,
   output logic                     in_ready,
   output logic                     out_valid,
   output s5gp_pkg::rsp_word_type   out_word,
   input  logic                     out_ready
);
   import s5gp_pkg::*;

   parser_state_type state_ff, state_in, cur;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             fire;
   logic [7:0]       b;
   logic [7:0]       methods_dec, left_dec;
   verdict_type      verdict;

   // result register frees up when empty or being taken
   assign in_ready = !rsp_valid_ff || out_ready;
   assign fire     = in_stage.valid && in_ready;
   assign b        = in_stage.word.data_byte;

   // step logic for one byte
   always_comb begin
      cur         = in_stage.word.new_connection ? STATE_RESET : state_ff;
      state_in    = cur;
      verdict     = V_UNFINISHED;
      methods_dec = cur.methods_remaining - 8'd1;
      left_dec    = cur.address_bytes_left - 8'd1;
      rsp_word_in = '0;

      if (cur.verdict_given) begin
         verdict = V_IGNORED;
      end else begin
         unique case (cur.parse_phase)
            PH_GREET_VER: begin
               if (b != SOCKS_VERSION) verdict = V_AUTH_VER;
               else state_in.parse_phase = PH_NMETHODS;
            end
            PH_NMETHODS: begin
               state_in.methods_remaining = b;
               if (b == 8'd0) verdict = V_NO_METHOD;
               else state_in.parse_phase = PH_METHODS;
            end
            PH_METHODS: begin
               if (b == METHOD_NOAUTH) state_in.no_auth_offered = 1'b1;
               state_in.methods_remaining = methods_dec;
               if (methods_dec == 8'd0) begin
                  if (state_in.no_auth_offered) state_in.parse_phase = PH_REQ_VER;
                  else verdict = V_NO_METHOD;
               end
            end
            PH_REQ_VER: begin
               if (b != SOCKS_VERSION) verdict = V_PROTO;
               else state_in.parse_phase = PH_CMD;
            end
            PH_CMD: begin
               if (b != CMD_CONNECT) verdict = V_PROTO;
               else state_in.parse_phase = PH_RSV;
            end
            PH_RSV: begin
               if (b != RSV_VALUE) verdict = V_PROTO;
               else state_in.parse_phase = PH_ATYP;
            end
            PH_ATYP: begin
               state_in.address_position = 8'd0;
               if (b == ATYP_IPV4) begin
                  state_in.address_kind_held  = KIND_IPV4;
                  state_in.address_bytes_left = IPV4_LEN;
                  state_in.parse_phase        = PH_ADDR;
               end else if (b == ATYP_IPV6) begin
                  state_in.address_kind_held  = KIND_IPV6;
                  state_in.address_bytes_left = IPV6_LEN;
                  state_in.parse_phase        = PH_ADDR;
               end else begin
                  // unknown types are parsed as a length-prefixed hostname
                  state_in.address_kind_held = KIND_HOST;
                  state_in.parse_phase       = PH_HOSTLEN;
               end
            end
            PH_HOSTLEN: begin
               state_in.address_bytes_left = b;
               state_in.parse_phase = (b == 8'd0) ? PH_PORT_HI : PH_ADDR;
            end
            PH_ADDR: begin
               rsp_word_in.addr_byte_valid = 1'b1;
               rsp_word_in.addr_index      = cur.address_position;
               rsp_word_in.addr_byte       = b;
               state_in.address_position   = cur.address_position + 8'd1;
               state_in.address_bytes_left = left_dec;
               if (left_dec == 8'd0) state_in.parse_phase = PH_PORT_HI;
            end
            PH_PORT_HI: begin
               state_in.port_high_byte = b;
               state_in.parse_phase    = PH_PORT_LO;
            end
            PH_PORT_LO: begin
               rsp_word_in.dest_port = {cur.port_high_byte, b};
               verdict               = V_GRANTED;
            end
            default: begin
               // unreachable phase codes count as a protocol error
               verdict = V_PROTO;
            end
         endcase
         if (verdict != V_UNFINISHED) state_in.verdict_given = 1'b1;
      end

      rsp_word_in.verdict   = verdict;
      rsp_word_in.addr_kind = state_in.address_kind_held;
   end

   // result valid flag
   always_comb begin
      if (fire) rsp_valid_in = 1'b1;
      else if (out_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // parser state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_word  = rsp_word_ff;
endmodule

// ===== sv/socks5_greeting_request_parser_unit.sv =====
// Top level of the SOCKS5 greeting/request parser: one result word per client byte.
// A byte is first held in the input register, then its result word in the core's result register.
// Throughput: one byte per cycle while the response side keeps ready high.
// Both stages hold their word under backpressure; ready drops only when both are full.
// Reset (synchronous, active high) empties both stages and returns the parser to
// awaiting the greeting version byte; no clearing pass is needed.
module socks5_greeting_request_parser_unit (
   input  logic       clock,
   input  logic       reset,
   s5gp_req_if.sink   req_if,
   s5gp_rsp_if.source rsp_if
);
   import s5gp_pkg::*;

   req_word_type   req_word;
   rsp_word_type   rsp_word;
   stage_word_type stage;
   logic           core_ready;

   assign req_word.data_byte      = req_if.data_byte;
   assign req_word.new_connection = req_if.new_connection;

   // input register
   s5gp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_word    (req_word),
      .in_ready   (req_if.ready),
      .down_ready (core_ready),
      .out_stage  (stage)
   );

   // parser state and result register
   s5gp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (stage),
      .in_ready  (core_ready),
      .out_valid (rsp_if.valid),
      .out_word  (rsp_word),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.verdict         = rsp_word.verdict;
   assign rsp_if.addr_kind       = rsp_word.addr_kind;
   assign rsp_if.addr_byte_valid = rsp_word.addr_byte_valid;
   assign rsp_if.addr_index      = rsp_word.addr_index;
   assign rsp_if.addr_byte       = rsp_word.addr_byte;
   assign rsp_if.dest_port       = rsp_word.dest_port;
endmodule
